// ===== design/rd_pkg.sv =====
// shared constants, command codes and types for the reversible deque
// no dependencies; imported by reversible_deque_top and rd_checker
package rd_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_REVERSE = 2'd1;
  localparam logic [1:0] CMD_DELETE  = 2'd2;
  localparam logic [1:0] CMD_FLUSH   = 2'd3;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       error;
    logic       empty;
  } res_t;

  typedef struct packed {
    logic valid;
    logic from_ram;
    logic last;
    logic error;
    logic empty;
  } pend_t;

  // (base + off) mod DEPTH, with base < DEPTH and off <= DEPTH
  function automatic logic [AW-1:0] ring_idx(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [AW:0] s;
    s = (AW+1)'(base) + (AW+1)'(off);
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

endpackage

// ===== design/reversible_deque_top.sv =====
// reversible deque top level: command decode, flush sequencer, output queue
// depends on rd_pkg and rd_ram
//
// A bounded deque of up to DEPTH bytes kept in a ring memory, with a lazy
// reverse flag. Load, reverse and delete requests are taken one per cycle while
// idle and produce no result. A flush request holds in_ready low until one read
// per stored byte is issued (an error or an empty store gives one synthetic
// result and no read); the sequencer issues one ring-memory read per cycle
// while the output queue has room. Read data returns in the cycle after its
// read (the memory's registered read port) and is then written into a
// two-entry output queue, so a result passes the read register and the queue
// register before it is offered. Results stream out at one per cycle while the
// consumer is ready, and a stalled consumer holds the sequencer but never loses
// a result. Request acceptance resumes in the cycle after the last read of a
// flush is issued, while its final results may still be waiting at the output.
// There is no clearing pass after reset: only written entries are ever read.
module reversible_deque_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_value_res,
  output logic       out_last,
  output logic       out_error,
  output logic       out_empty_res
);
  import rd_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  // architectural deque state
  logic          state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rev_r, rev_nxt;
  logic          fail_r, fail_nxt;
  // flush sequencer: number of reads issued so far
  logic [CW-1:0] idx_r, idx_nxt;
  // read in flight, its data shows up next cycle
  pend_t         pend_r, pend_nxt;
  // two-entry output queue
  res_t          fifo_r [2];
  logic          wptr_r, rptr_r;
  logic [1:0]    occ_r, occ_nxt;

  logic          in_acc, pop, issue, credit_ok, special, issue_last;
  logic [1:0]    inflight;
  logic [CW-1:0] off;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;
  res_t          push_res;

  rd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // output side
  assign out_valid     = (occ_r != 2'd0);
  assign pop           = out_valid && out_ready;
  assign out_value_res = fifo_r[rptr_r].value;
  assign out_last      = fifo_r[rptr_r].last;
  assign out_error     = fifo_r[rptr_r].error;
  assign out_empty_res = fifo_r[rptr_r].empty;

  // queue slots taken or promised; issue only if a slot is free next cycle
  assign inflight  = occ_r + {1'b0, pend_r.valid};
  assign credit_ok = (inflight < 2'd2) || ((inflight == 2'd2) && pop);
  assign issue     = (state_r == ST_FLUSH) && credit_ok;

  // error or empty store: one synthetic result, no memory read
  assign special    = fail_r || (count_r == '0);
  assign issue_last = special || (idx_r == count_r - CW'(1));
  // logical order walks from the tail when reversed
  assign off        = rev_r ? (count_r - CW'(1) - idx_r) : idx_r;

  assign ram_we    = in_acc && (in_cmd == CMD_LOAD) && (count_r < CW'(DEPTH));
  assign ram_waddr = ring_idx(head_r, count_r);
  assign ram_re    = issue && !special;
  assign ram_raddr = ring_idx(head_r, off);

  assign push_res.value = pend_r.from_ram ? ram_rdata : 8'd0;
  assign push_res.last  = pend_r.last;
  assign push_res.error = pend_r.error;
  assign push_res.empty = pend_r.empty;

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    rev_nxt   = rev_r;
    fail_nxt  = fail_r;
    idx_nxt   = idx_r;
    pend_nxt  = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            CMD_LOAD: begin
              if (count_r < CW'(DEPTH)) count_nxt = count_r + CW'(1);
            end
            CMD_REVERSE: begin
              if (!fail_r) rev_nxt = !rev_r;
            end
            CMD_DELETE: begin
              if (!fail_r) begin
                if (count_r == '0) begin
                  fail_nxt = 1'b1;
                end else begin
                  if (!rev_r) head_nxt = ring_idx(head_r, CW'(1));
                  count_nxt = count_r - CW'(1);
                end
              end
            end
            CMD_FLUSH: begin
              state_nxt = ST_FLUSH;
              idx_nxt   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_FLUSH: begin
        if (issue) begin
          pend_nxt.valid    = 1'b1;
          pend_nxt.from_ram = !special;
          pend_nxt.last     = issue_last;
          pend_nxt.error    = fail_r;
          pend_nxt.empty    = !fail_r && (count_r == '0);
          idx_nxt           = idx_r + CW'(1);
          if (issue_last) begin
            // flush clears everything once the final read is out
            state_nxt = ST_IDLE;
            head_nxt  = '0;
            count_nxt = '0;
            rev_nxt   = 1'b0;
            fail_nxt  = 1'b0;
            idx_nxt   = '0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign occ_nxt = occ_r + {1'b0, pend_r.valid} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
      fail_r  <= 1'b0;
      idx_r   <= '0;
      pend_r  <= '0;
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      occ_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
      fail_r  <= fail_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
      occ_r   <= occ_nxt;
      if (pend_r.valid) wptr_r <= !wptr_r;
      if (pop) rptr_r <= !rptr_r;
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (pend_r.valid) fifo_r[wptr_r] <= push_res;
  end

endmodule

// ===== design/rd_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module rd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== design/rd_checker.sv =====
// port-level checker for the reversible deque, bound to the top level
// depends on rd_pkg and reversible_deque_top
module rd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_cmd,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_value_res,
  input logic       out_last,
  input logic       out_error,
  input logic       out_empty_res
);
  import rd_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // an error result is the only result of its flush and carries no byte
  a_err_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last && !out_empty_res && (out_value_res == 8'd0))
    else $error("malformed error result");

  // an empty result is the only result of its flush and carries no byte
  a_empty_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_last && !out_error && (out_value_res == 8'd0))
    else $error("malformed empty result");

  // a taken request other than a flush never stalls the input
  a_in_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd != CMD_FLUSH) |=> in_ready)
    else $error("non-flush request stalled the input");

endmodule

bind reversible_deque_top rd_checker u_rd_checker (.*);
